// File: src/sdtq_pkg.sv
`timescale 1ns / 1ps
package sdtq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TICK_BITS   = 32;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] CMD_QUERY = 2'd0;
    localparam logic [1:0] CMD_REL   = 2'd1;
    localparam logic [1:0] CMD_ABS   = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [1:0] KIND_TIME    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    typedef enum logic [3:0] {
        OP_QUERY = 4'b0001,
        OP_REL   = 4'b0010,
        OP_ABS   = 4'b0100,
        OP_TICK  = 4'b1000
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [7:0]           task_id;
        logic [TICK_BITS-1:0] ticks;
    } t_item;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_REL  = 2'b10
    } t_state;

endpackage

// File: src/sdtq_ifs.sv
`timescale 1ns / 1ps
interface sdtq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  task_id;
    logic [31:0] ticks;
    modport source (output valid, command, task_id, ticks, input ready);
    modport sink (input valid, command, task_id, ticks, output ready);
endinterface

interface sdtq_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  task_id_out;
    logic [31:0] time_value;
    logic        last;
    modport source (output valid, kind, task_id_out, time_value, last, input ready);
    modport sink (input valid, kind, task_id_out, time_value, last, output ready);
endinterface

// File: src/sorted_delay_timer_queue_unit.sv
`timescale 1ns / 1ps
// a result is registered in the output register; the back end pops a request only when it is free
// throughput: a request per cycle while the 2-entry queue has room; the back end one per idle cycle
// a tick bumps the counter and enters S_REL, which releases due head tasks one at a time
// delays insert into the sorted shift chain in place; no clearing pass is needed
// reset: synchronous active low, clears counter, queue count, fsm and valid flags
module sorted_delay_timer_queue_unit
    import sdtq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdtq_req_if.sink   i_req,
    sdtq_res_if.source o_res
);

    // front/back handoff
    t_item w_item;
    logic  w_item_valid;
    logic  w_pop;

    // front: accepts requests, decodes the command, buffers in a short queue
    sdtq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .o_ready      (i_req.ready),
        .i_command    (i_req.command),
        .i_task_id    (i_req.task_id),
        .i_ticks      (i_req.ticks),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    // back: tick counter, sorted wait queue, release sequencer, output register
    sdtq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .i_item        (w_item),
        .o_pop         (w_pop),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_kind        (o_res.kind),
        .o_task_id_out (o_res.task_id_out),
        .o_time_value  (o_res.time_value),
        .o_last        (o_res.last)
    );

endmodule

// File: src/sdtq_front.sv
`timescale 1ns / 1ps
module sdtq_front
    import sdtq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_task_id,
    input  logic [31:0] i_ticks,
    output logic       o_item_valid,
    output t_item      o_item,
    input  logic       i_pop
);

    t_item               r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FCNT_W-1:0]   r_cnt, n_cnt;
    t_item               w_item;
    logic                w_push;
    logic                w_pop;

    // decode the command into a one-hot operation
    always_comb begin
        w_item.task_id = i_task_id;
        w_item.ticks   = TICK_BITS'(i_ticks);
        case (i_command)
            CMD_QUERY: w_item.op = OP_QUERY;
            CMD_REL:   w_item.op = OP_REL;
            CMD_ABS:   w_item.op = OP_ABS;
            default:   w_item.op = OP_TICK;
        endcase
    end

    assign o_ready      = (r_cnt != FCNT_W'(FIFO_DEPTH));
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != '0);
    assign w_pop        = i_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + FCNT_W'(w_push) - FCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

// File: src/sdtq_back.sv
`timescale 1ns / 1ps
module sdtq_back
    import sdtq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_task_id_out,
    output logic [31:0] o_time_value,
    output logic        o_last
);

    t_state               r_state, n_state;
    logic [TICK_BITS-1:0] r_elapsed, n_elapsed;
    logic [QCNT_W-1:0]    r_count, n_count;
    logic [TICK_BITS-1:0] r_wake [QUEUE_DEPTH];
    logic [7:0]           r_task [QUEUE_DEPTH];
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_kind, n_kind;
    logic [7:0]           r_tid, n_tid;
    logic                 r_last, n_last;

    logic                 w_out_free;
    logic                 w_head_due;
    logic                 w_next_due;
    logic [TICK_BITS:0]   w_sum;
    logic [TICK_BITS-1:0] w_ins_wake;
    logic                 w_past;
    logic                 w_full;
    logic                 w_le [QUEUE_DEPTH];
    logic                 w_ins;
    logic                 w_shift;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_head_due = (r_count != '0) && (r_wake[0] <= r_elapsed);
    assign w_next_due = (r_count > QCNT_W'(1)) && (r_wake[1] <= r_elapsed);
    assign w_sum      = {1'b0, r_elapsed} + {1'b0, i_item.ticks};
    assign w_past     = i_item.ticks < r_elapsed;
    assign w_full     = (r_count == QCNT_W'(QUEUE_DEPTH));

    // saturating relative wake time, or the absolute deadline as given
    always_comb begin
        if (i_item.op == OP_REL) begin
            w_ins_wake = w_sum[TICK_BITS] ? '1 : w_sum[TICK_BITS-1:0];
        end else begin
            w_ins_wake = i_item.ticks;
        end
    end

    // each cell tells whether it stays ahead of the new entry
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_le[i] = (QCNT_W'(i) < r_count) && (r_wake[i] <= w_ins_wake);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_elapsed   = r_elapsed;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        n_kind      = r_kind;
        n_tid       = r_tid;
        n_last      = r_last;
        o_pop       = 1'b0;
        w_ins       = 1'b0;
        w_shift     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid && w_out_free) begin
                    o_pop = 1'b1;
                    case (i_item.op)
                        OP_QUERY: begin
                            n_out_valid = 1'b1;
                            n_kind      = KIND_TIME;
                            n_tid       = i_item.task_id;
                            n_last      = 1'b1;
                        end
                        OP_TICK: begin
                            n_elapsed = r_elapsed + 1'b1;
                            n_state   = S_REL;
                        end
                        default: begin
                            if (i_item.op == OP_ABS && w_past) begin
                                n_out_valid = 1'b1;
                                n_kind      = KIND_RELEASE;
                                n_tid       = i_item.task_id;
                                n_last      = 1'b1;
                            end else if (w_full) begin
                                n_out_valid = 1'b1;
                                n_kind      = KIND_FULL;
                                n_tid       = i_item.task_id;
                                n_last      = 1'b1;
                            end else begin
                                w_ins   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_REL: begin
                if (!w_head_due) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_RELEASE;
                    n_tid       = r_task[0];
                    n_last      = !w_next_due;
                    w_shift     = 1'b1;
                    n_count     = r_count - 1'b1;
                    if (!w_next_due) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_tid  <= n_tid;
        r_last <= n_last;
    end

    // sorted shift chain: insert opens a gap, release moves everything forward
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_ins && !w_le[i]) begin
                if (i == 0 || w_le[(i == 0) ? 0 : i - 1]) begin
                    r_wake[i] <= w_ins_wake;
                    r_task[i] <= i_item.task_id;
                end else begin
                    r_wake[i] <= r_wake[(i == 0) ? 0 : i - 1];
                    r_task[i] <= r_task[(i == 0) ? 0 : i - 1];
                end
            end else if (w_shift && i < QUEUE_DEPTH - 1) begin
                r_wake[i] <= r_wake[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                r_task[i] <= r_task[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_task_id_out = r_tid;
    assign o_time_value  = 32'(r_elapsed);
    assign o_last        = r_last;

endmodule

// File: src/sdtq_checker.sv
`timescale 1ns / 1ps
module sdtq_checker
    import sdtq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [31:0] i_time_value,
    input logic        i_last
);

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_time_value))
        else $error("stalled result changed");

    // single-result kinds always close their request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_TIME || i_kind == KIND_FULL) |-> i_last)
        else $error("time reply or rejection without last");

    // releases of one tick share the same time value
    a_burst_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last ##1 i_valid |-> i_time_value == $past(i_time_value))
        else $error("time value changed inside a release burst");

endmodule

bind sorted_delay_timer_queue_unit sdtq_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_kind       (o_res.kind),
    .i_time_value (o_res.time_value),
    .i_last       (o_res.last)
);

// File: tb/sorted_delay_timer_queue_unit_tb.sv
`timescale 1ns / 1ps
module sorted_delay_timer_queue_unit_tb;
    import sdtq_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  task_id_out;
        logic [31:0] time_value;
        logic        last;
    } t_release;

    logic i_clk;
    logic i_rst_n;
    sdtq_req_if req_if ();
    sdtq_res_if res_if ();

    sorted_delay_timer_queue_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    // shadow copy of the timer queue
    logic [31:0] now_ticks;
    logic [31:0] wake_q[$];
    logic [7:0]  task_q[$];
    t_release    pending_q[$];
    int          errors;
    int          cycles;
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // queue one result in the order the block sends them
    task automatic push_result(input logic [1:0] k, input logic [7:0] tid, input logic l);
        t_release r;
        r.kind = k;
        r.task_id_out = tid;
        r.time_value = now_ticks;
        r.last = l;
        pending_q.push_back(r);
    endtask

    // stable sorted insert, or a full reject
    task automatic insert_wake(input logic [31:0] wake, input logic [7:0] tid);
        int pos;
        pos = 0;
        if (wake_q.size() >= QUEUE_DEPTH) begin
            push_result(KIND_FULL, tid, 1'b1);
        end else begin
            while (pos < wake_q.size() && wake_q[pos] <= wake) pos++;
            wake_q.insert(pos, wake);
            task_q.insert(pos, tid);
        end
    endtask

    task automatic predict_timer(input logic [1:0] cmd, input logic [7:0] tid,
                                 input logic [31:0] tk);
        int n;
        logic [32:0] sum;
        n = 0;
        case (cmd)
            CMD_TICK: begin
                now_ticks = now_ticks + 32'd1;
                while (n < wake_q.size() && wake_q[n] <= now_ticks) n++;
                for (int j = 0; j < n; j++) push_result(KIND_RELEASE, task_q[j], j + 1 == n);
                for (int j = 0; j < n; j++) begin
                    void'(wake_q.pop_front());
                    void'(task_q.pop_front());
                end
            end
            CMD_QUERY: push_result(KIND_TIME, tid, 1'b1);
            CMD_REL: begin
                sum = {1'b0, now_ticks} + {1'b0, tk};
                insert_wake(sum[32] ? 32'hFFFF_FFFF : sum[31:0], tid);
            end
            default: begin
                if (tk >= now_ticks) insert_wake(tk, tid);
                else push_result(KIND_RELEASE, tid, 1'b1);
            end
        endcase
    endtask

    // sender: drive at falling edge, hold until accepted
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] tid,
                                input logic [31:0] tk);
        while (!calm && $urandom_range(99) < 11) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.task_id <= tid;
        req_if.ticks   <= tk;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_timer(cmd, tid, tk);
        @(negedge i_clk);
    endtask

    // receiver stalls at random
    always @(negedge i_clk) begin
        res_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
    end

    // result checker
    always @(posedge i_clk) begin
        t_release e;
        cycles <= cycles + 1;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result kind=%0d task=%0d", res_if.kind, res_if.task_id_out);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (res_if.kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, res_if.kind);
                    errors++;
                end
                if (res_if.task_id_out !== e.task_id_out) begin
                    $error("task_id_out exp %0d got %0d", e.task_id_out, res_if.task_id_out);
                    errors++;
                end
                if (res_if.time_value !== e.time_value) begin
                    $error("time_value exp %0d got %0d", e.time_value, res_if.time_value);
                    errors++;
                end
                if (res_if.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, res_if.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(CMD_QUERY, 8'd0, 32'd0);
        send_request(CMD_TICK, 8'd0, 32'd0);       // tick with nothing due
        send_request(CMD_REL, 8'd1, 32'd0);
        send_request(CMD_REL, 8'd2, 32'd2);
        send_request(CMD_REL, 8'd3, 32'd2);        // equal wake keeps order
        send_request(CMD_ABS, 8'd4, 32'd1);        // deadline equal to now
        send_request(CMD_ABS, 8'd5, 32'd0);        // deadline already past
        send_request(CMD_REL, 8'd255, 32'hFFFF_FFFF); // saturating delay
        send_request(CMD_ABS, 8'd6, 32'hFFFF_FFFF);
        send_request(CMD_TICK, 8'hFF, 32'hFFFF_FFFF); // releases tasks 1 and 4
        send_request(CMD_TICK, 8'd0, 32'd0);
        send_request(CMD_TICK, 8'd0, 32'd0);
        send_request(CMD_QUERY, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // fill the queue past its depth, then flush with ticks
    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            send_request(CMD_REL, i[7:0], $urandom_range(3, 1));
        for (int i = 0; i < 4; i++) send_request(CMD_TICK, 8'd0, 32'd0);
        send_request(CMD_ABS, 8'd7, 32'hFFFF_FFFF);
        send_request(CMD_REL, 8'd8, 32'hFFFF_FFFF);
    endtask

    task automatic test_random();
        logic [1:0]  cmd;
        logic [31:0] tk;
        for (int i = 0; i < 20; i++) begin
            calm = (i >= 4 && i < 16);
            cmd = 2'($urandom_range(3));
            case ($urandom_range(3))
                0: tk = $urandom;
                1: tk = now_ticks + $urandom_range(4);
                default: tk = $urandom_range(5);
            endcase
            if (cmd == CMD_ABS && $urandom_range(1)) tk = now_ticks - $urandom_range(2);
            send_request(cmd, 8'($urandom_range(255)), tk);
        end
        calm = 1'b0;
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        now_ticks = '0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.command = CMD_QUERY;
        req_if.task_id = '0;
        req_if.ticks = '0;
        res_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_full_queue();
        test_random();
        req_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

// File: sorted_delay_timer_queue_unit.f
src/sdtq_pkg.sv
src/sdtq_ifs.sv
src/sdtq_front.sv
src/sdtq_back.sv
src/sorted_delay_timer_queue_unit.sv
src/sdtq_checker.sv
tb/sorted_delay_timer_queue_unit_tb.sv
